// ----- sv/hbk_pkg.sv -----
// Shared types, constants and the usage-to-matrix table for the boot keyboard translator.
// No dependencies.
package hbk_pkg;

   localparam int KEY_SLOTS    = 6;              // slots that take part in a report
   localparam int REPORT_SLOTS = 6;              // slot fields carried by every report
   localparam int NUM_EVENTS   = KEY_SLOTS + 1;  // one per slot plus the release event
   localparam int QUEUE_DEPTH  = 2;              // power of two: pointers wrap naturally

   localparam logic [7:0] USAGE_F12   = 8'h45;
   localparam logic [7:0] USAGE_FIRST = 8'h04;
   localparam logic [7:0] USAGE_LAST  = 8'h39;
   localparam logic [7:0] NO_KEY      = 8'hFF;
   localparam logic [7:0] SHIFT_MASK  = 8'h22;
   localparam logic [7:0] CTRL_MASK   = 8'h11;
   localparam int         TABLE_SIZE  = 54;
   localparam int         TABLE_IDX_W = $clog2(TABLE_SIZE);

   typedef enum logic [1:0] {
      EV_KEY_DOWN = 2'd0,
      EV_BREAK    = 2'd1,
      EV_RELEASE  = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     code;
   } event_type;

   // One classified report: events in output order, mask marks those that exist.
   typedef struct packed {
      logic [NUM_EVENTS-1:0]            mask;
      event_type [NUM_EVENTS-1:0]       events;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type data;
   } queue_rd_type;

   localparam logic [7:0] USAGE_TABLE [TABLE_SIZE] = '{
      8'h3F, 8'h15, 8'h12, 8'h3A, 8'h2A, 8'h38, 8'h3D, 8'h39, 8'h0D, 8'h01, 8'h05, 8'h00,
      8'h25, 8'h23, 8'h08, 8'h0A, 8'h2F, 8'h28, 8'h3E, 8'h2D, 8'h0B, 8'h10, 8'h2E, 8'h16,
      8'h2B, 8'h17, 8'h1F, 8'h1E, 8'h1A, 8'h18, 8'h1D, 8'h1B, 8'h33, 8'h35, 8'h30, 8'h32,
      8'h0C, 8'h1C, 8'h34, 8'h2C, 8'h21, 8'h0E, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02,
      8'hFF, 8'hFF, 8'h20, 8'h22, 8'h26, 8'h3C
   };

   // Matrix value of a usage, NO_KEY outside the table range.
   function automatic logic [7:0] usage_map(input logic [7:0] usage);
      logic [7:0] offset;
      logic [7:0] value;
      offset = usage - USAGE_FIRST;
      if (usage >= USAGE_FIRST && usage <= USAGE_LAST) begin
         value = USAGE_TABLE[offset[TABLE_IDX_W-1:0]];
      end else begin
         value = NO_KEY;
      end
      return value;
   endfunction

endpackage

// ----- sv/hbk_front.sv -----
// Front end: takes a report, compares it with the stored keys and builds one job.
// Depends on hbk_pkg.
module hbk_front
   import hbk_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              is_keyboard_report,
   input  logic [7:0]                        modifiers,
   input  logic [REPORT_SLOTS-1:0][7:0]      keys,
   output logic                              job_push,
   output job_type                           job
);

   logic [KEY_SLOTS-1:0][7:0] prev_keys_ff, prev_keys_in;
   logic                      held_ff, held_in;
   logic                      mapped_now;

   always_comb begin
      logic       shift;
      logic       ctrl;
      logic       fresh;
      logic [7:0] k;
      logic [7:0] m;
      shift      = (modifiers & SHIFT_MASK) != 8'h00;
      ctrl       = (modifiers & CTRL_MASK) != 8'h00;
      mapped_now = 1'b0;
      job        = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         k     = keys[i];
         fresh = 1'b1;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_keys_ff[j] == k) fresh = 1'b0;
         end
         m = usage_map(k);
         job.events[i].kind = EV_KEY_DOWN;
         job.events[i].code = 8'h00;
         if (k == USAGE_F12) begin
            job.mask[i]        = fresh;
            job.events[i].kind = EV_BREAK;
         end else if (m != NO_KEY) begin
            mapped_now         = 1'b1;
            job.mask[i]        = fresh;
            job.events[i].code = {ctrl, shift, m[5:0]};
         end
      end
      job.mask[NUM_EVENTS-1]        = !mapped_now && held_ff;
      job.events[NUM_EVENTS-1].kind = EV_RELEASE;
      job.events[NUM_EVENTS-1].code = 8'h00;
   end

   assign job_push = accept && is_keyboard_report && (job.mask != '0);

   always_comb begin
      prev_keys_in = prev_keys_ff;
      held_in      = held_ff;
      if (accept && is_keyboard_report) begin
         prev_keys_in = keys[KEY_SLOTS-1:0];
         held_in      = mapped_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
         held_ff      <= 1'b0;
      end else begin
         prev_keys_ff <= prev_keys_in;
         held_ff      <= held_in;
      end
   end

endmodule

// ----- sv/hbk_job_queue.sv -----
// Short job queue between the front end and the event sequencer.
// Depends on hbk_pkg.
module hbk_job_queue
   import hbk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      wr_data,
   output logic         full,
   input  logic         pop,
   output queue_rd_type rd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign do_push  = push && !full;
   assign do_pop   = pop && (count_ff != '0);

   always_comb begin
      rd.valid = count_ff != '0;
      rd.data  = entries_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/hbk_back.sv -----
// Sequencer: head job events go one per cycle into the result register when free or popped.
// Depends on hbk_pkg.
module hbk_back
   import hbk_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           job_valid,
   input  job_type        job,
   output logic           job_pop,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output logic [1:0]     rsp_event_kind,
   output logic [7:0]     rsp_key_code,
   output logic           rsp_last_of_run
);

   logic [NUM_EVENTS-1:0] done_ff, done_in;
   logic                  out_valid_ff, out_valid_in;
   event_type             out_event_ff, out_event_in;
   logic                  out_last_ff, out_last_in;
   logic [NUM_EVENTS-1:0] remaining, sel_bit;
   event_type             sel_event;
   logic                  is_last, load;

   assign remaining = job.mask & ~done_ff;
   assign sel_bit   = remaining & (~remaining + 1'b1);
   assign is_last   = (remaining & ~sel_bit) == '0;
   assign load      = job_valid && (!out_valid_ff || rsp_pop);
   assign job_pop   = load && is_last;

   always_comb begin
      sel_event = '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         if (sel_bit[i]) sel_event = job.events[i];
      end
   end

   always_comb begin
      done_in      = done_ff;
      out_valid_in = out_valid_ff;
      out_event_in = out_event_ff;
      out_last_in  = out_last_ff;
      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         out_event_in = sel_event;
         out_last_in  = is_last;
         // advance within the job, or drop it once its last event is out
         done_in      = is_last ? '0 : (done_ff | sel_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
      out_event_ff <= out_event_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_event_kind  = out_event_ff.kind;
   assign rsp_key_code    = out_event_ff.code;
   assign rsp_last_of_run = out_last_ff;

endmodule

// ----- sv/hid_boot_keyboard_translator.sv -----
// Top level of the boot keyboard report translator: front end, job queue, event sequencer.
// Depends on hbk_pkg, hbk_front, hbk_job_queue and hbk_back.
//
//   channel   direction   handshake                 payload
//   req_      in          push / full               is_keyboard_report, modifiers, key_slot0..5
//   rsp_      out         empty / pop               event_kind, key_code, last_of_run
//
// A report is taken in every cycle while the job queue has room; ignored and eventless
// reports leave nothing in the queue. The sequencer issues one event per cycle while its
// result register is free or popped. A report yields at most seven events; the first
// goes through the job queue, then the result register. Reset clears the stored keys, queue
// and result register. A stalled result holds the sequencer; the queue absorbs up to two jobs.
module hid_boot_keyboard_translator
   import hbk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_is_keyboard_report,
   input  logic [7:0] req_modifiers,
   input  logic [7:0] req_key_slot0,
   input  logic [7:0] req_key_slot1,
   input  logic [7:0] req_key_slot2,
   input  logic [7:0] req_key_slot3,
   input  logic [7:0] req_key_slot4,
   input  logic [7:0] req_key_slot5,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_key_code,
   output logic       rsp_last_of_run
);

   logic [REPORT_SLOTS-1:0][7:0] keys;
   logic                         job_push;
   logic                         job_full;
   job_type                      job_data;
   queue_rd_type                 qrd;
   logic                         back_pop;

   assign keys = {req_key_slot5, req_key_slot4, req_key_slot3,
                  req_key_slot2, req_key_slot1, req_key_slot0};

   assign req_full = job_full;

   hbk_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (req_push && !job_full),
      .is_keyboard_report (req_is_keyboard_report),
      .modifiers          (req_modifiers),
      .keys               (keys),
      .job_push           (job_push),
      .job                (job_data)
   );

   hbk_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_data),
      .full    (job_full),
      .pop     (back_pop),
      .rd      (qrd)
   );

   hbk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (qrd.valid),
      .job             (qrd.data),
      .job_pop         (back_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_key_code    (rsp_key_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   a_kind_legal : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_event_kind == EV_KEY_DOWN || rsp_event_kind == EV_BREAK ||
                      rsp_event_kind == EV_RELEASE))
      else $error("illegal event kind");

   a_code_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind != EV_KEY_DOWN) |-> rsp_key_code == 8'h00)
      else $error("break or release event carries a key code");

   a_release_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_event_kind == EV_RELEASE) |-> rsp_last_of_run)
      else $error("release event not last of its report");

   a_pop_has_job : assert property (@(posedge clock) disable iff (reset)
      back_pop |-> qrd.valid)
      else $error("sequencer retired a job from an empty queue");

endmodule

// ----- bench/hbk_key_event_checker.sv -----
`timescale 1ns / 100ps
// Checker for the boot keyboard translator: watches both channels, predicts the key events
// of every accepted report and compares them in order. Depends on hbk_pkg.
module hbk_key_event_checker
   import hbk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_is_keyboard_report,
   input  logic [7:0] req_modifiers,
   input  logic [7:0] req_key_slot0,
   input  logic [7:0] req_key_slot1,
   input  logic [7:0] req_key_slot2,
   input  logic [7:0] req_key_slot3,
   input  logic [7:0] req_key_slot4,
   input  logic [7:0] req_key_slot5,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [1:0] rsp_event_kind,
   input  logic [7:0] rsp_key_code,
   input  logic       rsp_last_of_run,
   output int         failures,
   output int         events_waiting,
   output int         events_checked
);

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     code;
      logic           last;
   } key_event_type;

   key_event_type expected_events[$];
   logic [7:0] stored_keys [REPORT_SLOTS];
   logic       mapped_held;
   int         fail_count;
   int         checked_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Work out the events one report causes and update the stored keys.
   task automatic translate_report(input logic [7:0] mods,
                                   input logic [REPORT_SLOTS-1:0][7:0] keys);
      logic           shift_on;
      logic           ctrl_on;
      logic           mapped_now;
      logic           fresh;
      logic [7:0]     matrix;
      event_kind_type kinds [NUM_EVENTS];
      logic [7:0]     codes [NUM_EVENTS];
      int             n;
      key_event_type  ev;
      shift_on   = (mods & SHIFT_MASK) != 8'h00;
      ctrl_on    = (mods & CTRL_MASK) != 8'h00;
      mapped_now = 1'b0;
      n          = 0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         fresh = 1'b1;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (stored_keys[j] == keys[i]) fresh = 1'b0;
         end
         if (keys[i] == USAGE_F12) begin
            if (fresh) begin
               kinds[n] = EV_BREAK;
               codes[n] = 8'h00;
               n++;
            end
         end else if (keys[i] >= USAGE_FIRST && keys[i] <= USAGE_LAST) begin
            matrix = USAGE_TABLE[keys[i] - USAGE_FIRST];
            if (matrix != NO_KEY) begin
               mapped_now = 1'b1;
               if (fresh) begin
                  kinds[n] = EV_KEY_DOWN;
                  codes[n] = {ctrl_on, shift_on, matrix[5:0]};
                  n++;
               end
            end
         end
      end
      if (!mapped_now && mapped_held) begin
         kinds[n] = EV_RELEASE;
         codes[n] = 8'h00;
         n++;
      end
      mapped_held = mapped_now;
      for (int i = 0; i < KEY_SLOTS; i++) stored_keys[i] = keys[i];
      for (int i = 0; i < n; i++) begin
         ev.kind = kinds[i];
         ev.code = codes[i];
         ev.last = (i == n - 1);
         expected_events.push_back(ev);
      end
   endtask

   task automatic check_event();
      key_event_type ev;
      if (expected_events.size() == 0) begin
         report_mismatch("event with nothing expected, kind", int'(rsp_event_kind), 0);
      end else begin
         ev = expected_events.pop_front();
         if (rsp_event_kind != ev.kind)
            report_mismatch("event_kind", int'(rsp_event_kind), int'(ev.kind));
         if (rsp_key_code != ev.code)
            report_mismatch("key_code", int'(rsp_key_code), int'(ev.code));
         if (rsp_last_of_run != ev.last)
            report_mismatch("last_of_run", int'(rsp_last_of_run), int'(ev.last));
      end
      checked_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_events.delete();
         for (int i = 0; i < REPORT_SLOTS; i++) stored_keys[i] = 8'h00;
         mapped_held   = 1'b0;
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) check_event();
         if (req_push && !req_full && req_is_keyboard_report) begin
            translate_report(req_modifiers, {req_key_slot5, req_key_slot4, req_key_slot3,
                                             req_key_slot2, req_key_slot1, req_key_slot0});
         end
      end
      failures       <= fail_count;
      events_waiting <= expected_events.size();
      events_checked <= checked_count;
   end

endmodule

// ----- bench/tb_hid_boot_keyboard_translator.sv -----
`timescale 1ns / 100ps
// Testbench top for the boot keyboard translator: clock, reset, report stimulus, result
// pop pattern and verdict. Depends on hbk_pkg, the translator and hbk_key_event_checker.
module tb_hid_boot_keyboard_translator
   import hbk_pkg::*;
;

   localparam int RANDOM_REPORTS = 300;
   localparam int HOLD_OFF       = 80;

   logic       clock                  = 1'b0;
   logic       reset                  = 1'b1;
   logic       req_push               = 1'b0;
   logic       req_full;
   logic       req_is_keyboard_report = 1'b0;
   logic [7:0] req_modifiers          = 8'h00;
   logic [7:0] req_key_slot0          = 8'h00;
   logic [7:0] req_key_slot1          = 8'h00;
   logic [7:0] req_key_slot2          = 8'h00;
   logic [7:0] req_key_slot3          = 8'h00;
   logic [7:0] req_key_slot4          = 8'h00;
   logic [7:0] req_key_slot5          = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop                = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [7:0] rsp_key_code;
   logic       rsp_last_of_run;

   int failures;
   int events_waiting;
   int events_checked;

   int burst_left     = 0;
   int keyboard_sent  = 0;
   int ignored_sent   = 0;
   int full_cycles    = 0;
   logic [7:0] held_keys [REPORT_SLOTS];

   always #2 clock = ~clock;

   hid_boot_keyboard_translator i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_is_keyboard_report (req_is_keyboard_report),
      .req_modifiers          (req_modifiers),
      .req_key_slot0          (req_key_slot0),
      .req_key_slot1          (req_key_slot1),
      .req_key_slot2          (req_key_slot2),
      .req_key_slot3          (req_key_slot3),
      .req_key_slot4          (req_key_slot4),
      .req_key_slot5          (req_key_slot5),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_key_code           (rsp_key_code),
      .rsp_last_of_run        (rsp_last_of_run)
   );

   hbk_key_event_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_is_keyboard_report (req_is_keyboard_report),
      .req_modifiers          (req_modifiers),
      .req_key_slot0          (req_key_slot0),
      .req_key_slot1          (req_key_slot1),
      .req_key_slot2          (req_key_slot2),
      .req_key_slot3          (req_key_slot3),
      .req_key_slot4          (req_key_slot4),
      .req_key_slot5          (req_key_slot5),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_key_code           (rsp_key_code),
      .rsp_last_of_run        (rsp_last_of_run),
      .failures               (failures),
      .events_waiting         (events_waiting),
      .events_checked         (events_checked)
   );

   // Offer one report and hold it until the transfer; bursts and gaps are decided here.
   task automatic offer_report(input logic kb, input logic [7:0] mods,
                               input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] s2, input logic [7:0] s3,
                               input logic [7:0] s4, input logic [7:0] s5);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_push               <= 1'b1;
      req_is_keyboard_report <= kb;
      req_modifiers          <= mods;
      req_key_slot0          <= s0;
      req_key_slot1          <= s1;
      req_key_slot2          <= s2;
      req_key_slot3          <= s3;
      req_key_slot4          <= s4;
      req_key_slot5          <= s5;
      @(posedge clock);
      while (req_full) begin
         full_cycles++;
         @(posedge clock);
      end
      if (kb) keyboard_sent++;
      else ignored_sent++;
   endtask

   // Mostly mapped usages, with F12, empty slots and unmapped codes mixed in.
   function automatic logic [7:0] pick_usage();
      logic [7:0] usage;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: usage = 8'($urandom_range(USAGE_FIRST, USAGE_LAST));
         6:                usage = USAGE_F12;
         7:                usage = 8'h00;
         8:                usage = 8'($urandom_range(0, 255));
         default:          usage = 8'($urandom_range(USAGE_LAST + 1, 255));
      endcase
      return usage;
   endfunction

   task automatic offer_held_keys(input logic [7:0] mods);
      offer_report(1'b1, mods, held_keys[0], held_keys[1], held_keys[2],
                   held_keys[3], held_keys[4], held_keys[5]);
   endtask

   initial begin
      int random_sent;
      int slot;
      random_sent = 0;
      for (int i = 0; i < REPORT_SLOTS; i++) held_keys[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty report, first and last table entries, held key, release
      offer_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h00, USAGE_FIRST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h00, USAGE_FIRST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, USAGE_LAST);
      // each Ctrl and Shift bit alone, then the bits that mean nothing
      offer_report(1'b1, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h10, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h02, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h20, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'hCC, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      // six new keys with every modifier bit set
      offer_report(1'b1, 8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F);
      // six new F12 presses plus the release: the longest run
      offer_report(1'b1, 8'h00, USAGE_F12, USAGE_F12, USAGE_F12, USAGE_F12, USAGE_F12,
                   USAGE_F12);
      offer_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, USAGE_F12);
      // same usage in every slot
      offer_report(1'b1, 8'h11, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10);
      // unmapped codes and empty table entries only: release, nothing held
      offer_report(1'b1, 8'h00, 8'h03, 8'h3A, 8'hFF, 8'h2F, 8'h80, 8'h32);
      offer_report(1'b1, 8'h00, 8'h01, 8'h34, 8'h35, 8'h30, 8'h31, 8'h7F);
      // ignored report must leave the stored keys alone
      offer_report(1'b1, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b0, 8'hFF, 8'h21, 8'h22, 8'h23, 8'h24, USAGE_F12, 8'hFF);
      offer_report(1'b1, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      offer_report(1'b1, 8'h22, 8'h38, 8'h39, 8'h20, 8'h33, 8'h36, 8'h37);
      offer_report(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

      // random: keyboard sessions that press and release keys, with noise mixed in
      while (random_sent < RANDOM_REPORTS) begin
         case ($urandom_range(0, 9))
            0: begin
               offer_report(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            end
            1: begin
               for (int i = 0; i < REPORT_SLOTS; i++) held_keys[i] = 8'($urandom_range(0, 255));
               offer_held_keys(8'($urandom_range(0, 255)));
            end
            2: begin
               for (int i = 0; i < REPORT_SLOTS; i++) held_keys[i] = 8'h00;
               offer_held_keys(8'($urandom_range(0, 255)));
            end
            default: begin
               repeat ($urandom_range(1, 2)) begin
                  slot = $urandom_range(0, REPORT_SLOTS - 1);
                  held_keys[slot] = ($urandom_range(0, 2) == 0) ? 8'h00 : pick_usage();
               end
               if ($urandom_range(0, 7) == 0) begin
                  held_keys[$urandom_range(0, REPORT_SLOTS - 1)] =
                     held_keys[$urandom_range(0, REPORT_SLOTS - 1)];
               end
               offer_held_keys(8'($urandom_range(0, 255)));
            end
         endcase
         random_sent++;
      end
      req_push <= 1'b0;

      // skip the edge of the last transfer so the checker count is current
      @(posedge clock);
      while (events_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d keyboard reports and %0d ignored reports, %0d key events checked.",
               keyboard_sent, ignored_sent, events_checked);
      $display("Input held off by a full queue on %0d cycles.", full_cycles);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Receiver: pop patterns chosen at random in turn, plus two long hold-offs.
   initial begin
      int cycle_count;
      int hold_left;
      int mode;
      int mode_left;
      cycle_count = 0;
      hold_left   = 0;
      mode        = 0;
      mode_left   = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (cycle_count == 600 || cycle_count == 2200) begin
            hold_left = HOLD_OFF;
            rsp_pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= ($urandom_range(0, 4) == 0);
               default: rsp_pop <= (cycle_count % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      #2000000;
      $display("Timeout: results still outstanding or input never accepted");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/hbk_pkg.sv
sv/hbk_front.sv
sv/hbk_job_queue.sv
sv/hbk_back.sv
sv/hid_boot_keyboard_translator.sv
bench/hbk_key_event_checker.sv
bench/tb_hid_boot_keyboard_translator.sv
